// ===== hdl/cfd_pkg.sv =====
package cfd_pkg;
   localparam int DefInputWidth = 32;
   localparam int TwWidth = 6;
   localparam int FwWidth = 5;
   localparam logic [TwWidth-1:0] TwReset = 6'd32;
   localparam logic [FwWidth-1:0] FwReset = 5'd23;
   localparam logic [63:0] DblQnan = 64'h7FF8000000000000;
   localparam logic [63:0] DblInf = 64'h7FF0000000000000;

   typedef enum logic {
      CSR_TOTAL_WIDTH    = 1'b0,
      CSR_FRACTION_WIDTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic nan;
      logic inf;
      logic zero;
      logic sub;
      logic bad;
   } class_type;
endpackage

// ===== hdl/custom_float_to_double_top.sv =====
// channel | ports                         | transfer when
// req     | req_valid req_ready req_pattern | req_valid & req_ready
// rsp     | rsp_valid rsp_ready rsp_*     | rsp_valid & rsp_ready
// csr     | csr_write csr_index csr_data  | csr_write
// four register stages: align/classify, leading-one search, shift, pack;
// one item enters per cycle while the pipe is not stalled.
// synchronous reset clears valid bits and loads register defaults.
// a stall freezes the whole pipe; req_ready is low only when the last stage
// holds a result and rsp_ready is low.
module custom_float_to_double_top #(
   parameter int INPUT_WIDTH = cfd_pkg::DefInputWidth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [INPUT_WIDTH-1:0]     req_pattern,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [63:0]                rsp_double_bits,
   output logic                       rsp_is_nan,
   output logic                       rsp_is_infinite,
   output logic                       rsp_is_zero,
   output logic                       rsp_is_subnormal,
   output logic                       rsp_bad_config,
   input  logic                       csr_write,
   input  logic                       csr_index,
   input  logic [cfd_pkg::TwWidth-1:0] csr_data
);
   import cfd_pkg::*;

   logic [TwWidth-1:0] tw_ff;
   logic [FwWidth-1:0] fw_ff;
   logic advance;
   logic [3:0] vld_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff <= TwReset;
         fw_ff <= FwReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TOTAL_WIDTH:    tw_ff <= csr_data;
            CSR_FRACTION_WIDTH: fw_ff <= csr_data[FwWidth-1:0];
            default: ;
         endcase
      end
   end

   assign advance = !vld_ff[3] || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[2:0], req_valid};
   end

   // stage 1: mask, split fields, classify
   logic signed [7:0] ew;
   logic [63:0] pat_w;
   logic [31:0] f_w;
   logic [10:0] e_w, emax_w;
   logic sgn_w;
   logic bad_w;
   assign ew = $signed({2'b0, tw_ff}) - $signed({3'b0, fw_ff}) - 8'sd1;
   assign bad_w = (ew < 8'sd1) || (ew > 8'sd11);
   always_comb begin
      pat_w = 64'(req_pattern) & ((64'd1 << tw_ff) - 64'd1);
      sgn_w = pat_w[tw_ff - 6'd1];
      emax_w = 11'((12'd1 << ew[3:0]) - 12'd1);
      e_w = 11'(pat_w >> fw_ff) & emax_w;
      f_w = 32'(pat_w) & ((32'd1 << fw_ff) - 32'd1);
   end

   logic s1_sgn_ff; logic [10:0] s1_e_ff; logic [31:0] s1_f_ff;
   class_type s1_cls_ff; logic [3:0] s1_ew_ff; logic [FwWidth-1:0] s1_fw_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sgn_ff <= sgn_w; s1_e_ff <= e_w; s1_f_ff <= f_w;
         s1_ew_ff <= ew[3:0]; s1_fw_ff <= fw_ff;
         s1_cls_ff.bad  <= bad_w;
         s1_cls_ff.nan  <= !bad_w && e_w == emax_w && f_w != '0;
         s1_cls_ff.inf  <= !bad_w && e_w == emax_w && f_w == '0;
         s1_cls_ff.zero <= !bad_w && e_w == '0 && f_w == '0;
         s1_cls_ff.sub  <= !bad_w && e_w == '0 && f_w != '0;
      end
   end

   // stage 2: leading-one position and exponent
   logic [4:0] lz_w;
   always_comb begin
      lz_w = '0;
      for (int i = 0; i < 32; i++) if (s1_f_ff[i]) lz_w = 5'(i);
   end
   logic signed [12:0] bias_w, be_w;
   assign bias_w = 13'((13'd1 << (s1_ew_ff - 4'd1)) - 13'd1);
   always_comb begin
      if (s1_cls_ff.sub)
         be_w = 13'sd1 - bias_w - $signed({8'b0, s1_fw_ff})
                + $signed({8'b0, lz_w}) + 13'sd1023;
      else
         be_w = $signed({2'b0, s1_e_ff}) - bias_w + 13'sd1023;
   end

   logic s2_sgn_ff; logic [31:0] s2_f_ff; class_type s2_cls_ff;
   logic signed [12:0] s2_be_ff; logic [4:0] s2_p_ff; logic [FwWidth-1:0] s2_fw_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sgn_ff <= s1_sgn_ff; s2_f_ff <= s1_f_ff; s2_cls_ff <= s1_cls_ff;
         s2_be_ff <= be_w; s2_p_ff <= lz_w; s2_fw_ff <= s1_fw_ff;
      end
   end

   // stage 3: align fraction
   logic [51:0] frac_w;
   logic [10:0] bexp_w;
   always_comb begin
      bexp_w = s2_be_ff[10:0];
      if (s2_cls_ff.sub) begin
         if (s2_be_ff >= 13'sd1)
            frac_w = 52'({32'b0, s2_f_ff ^ (32'd1 << s2_p_ff)} << (6'd52 - {1'b0, s2_p_ff}));
         else begin
            // double subnormal: shift by be + 51 - p
            frac_w = 52'({32'b0, s2_f_ff} <<
                         6'(s2_be_ff + 13'sd51 - $signed({8'b0, s2_p_ff})));
            bexp_w = '0;
         end
      end else
         frac_w = 52'({32'b0, s2_f_ff} << (6'd52 - {1'b0, s2_fw_ff}));
   end

   logic s3_sgn_ff; class_type s3_cls_ff; logic [10:0] s3_exp_ff; logic [51:0] s3_frac_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s3_sgn_ff <= s2_sgn_ff; s3_cls_ff <= s2_cls_ff;
         s3_exp_ff <= bexp_w; s3_frac_ff <= frac_w;
      end
   end

   // stage 4: pack result
   logic [63:0] res_w;
   always_comb begin
      priority if (s3_cls_ff.bad) res_w = '0;
      else if (s3_cls_ff.nan)     res_w = DblQnan;
      else if (s3_cls_ff.inf)     res_w = {s3_sgn_ff, 63'b0} | DblInf;
      else if (s3_cls_ff.zero)    res_w = {s3_sgn_ff, 63'b0};
      else                        res_w = {s3_sgn_ff, s3_exp_ff, s3_frac_ff};
   end

   logic [63:0] s4_res_ff; class_type s4_cls_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s4_res_ff <= res_w; s4_cls_ff <= s3_cls_ff;
      end
   end

   assign rsp_valid = vld_ff[3];
   assign rsp_double_bits = s4_res_ff;
   assign rsp_is_nan = s4_cls_ff.nan;
   assign rsp_is_infinite = s4_cls_ff.inf;
   assign rsp_is_zero = s4_cls_ff.zero;
   assign rsp_is_subnormal = s4_cls_ff.sub;
   assign rsp_bad_config = s4_cls_ff.bad;

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_double_bits))
      else $error("result changed under stall");
   // at most one class flag
   a_cls: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_is_nan, rsp_is_infinite, rsp_is_zero,
                              rsp_is_subnormal, rsp_bad_config}))
      else $error("class flags overlap");
   // bad config gives zero
   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_config |-> rsp_double_bits == '0)
      else $error("bad config result nonzero");
endmodule

// ===== bench/tb_custom_float_to_double_top.sv =====
`timescale 1ns / 100ps

module tb_custom_float_to_double_top;
   import cfd_pkg::*;

   localparam int PatWidth = DefInputWidth;
   localparam int CycleLimit = 2000000;
   localparam int DrainCycles = 8;

   typedef struct packed {
      logic [63:0] dbl;
      class_type   flags;
   } conv_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PatWidth-1:0]  req_pattern = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [63:0]          rsp_double_bits;
   logic                 rsp_is_nan;
   logic                 rsp_is_infinite;
   logic                 rsp_is_zero;
   logic                 rsp_is_subnormal;
   logic                 rsp_bad_config;
   logic                 csr_write = 1'b0;
   csr_index_type        csr_index = CSR_TOTAL_WIDTH;
   logic [TwWidth-1:0]   csr_data = '0;

   // current format as the block should hold it
   logic [TwWidth-1:0]   fmt_total = TwReset;
   logic [FwWidth-1:0]   fmt_frac = FwReset;

   conv_result_type      pending_results[$];
   int                   error_count = 0;
   int                   cycle_count = 0;
   bit                   no_idle = 1'b0;
   int                   rsp_stall = 0;

   custom_float_to_double_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_pattern(req_pattern),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_double_bits(rsp_double_bits), .rsp_is_nan(rsp_is_nan),
      .rsp_is_infinite(rsp_is_infinite), .rsp_is_zero(rsp_is_zero),
      .rsp_is_subnormal(rsp_is_subnormal), .rsp_bad_config(rsp_bad_config),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   function automatic logic [63:0] low_ones(int n);
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
   endfunction

   // decode one minifloat pattern into its binary64 value and class
   function automatic conv_result_type convert(logic [PatWidth-1:0] pat_in,
                                               logic [TwWidth-1:0] tw_u,
                                               logic [FwWidth-1:0] fw_u);
      conv_result_type r;
      int tw, fw, ew, bias, scale, msb, bexp, sh;
      logic [63:0] pat, sgn, emax, e, f, frac;
      r = '0;
      tw = tw_u;
      fw = fw_u;
      ew = tw - fw - 1;
      if (ew < 1 || ew > 11) begin
         r.flags.bad = 1'b1;
         return r;
      end
      pat = {{(64-PatWidth){1'b0}}, pat_in} & low_ones(tw);
      sgn = (pat >> (tw - 1)) & 64'd1;
      emax = low_ones(ew);
      e = (pat >> fw) & emax;
      f = pat & low_ones(fw);
      bias = (1 << (ew - 1)) - 1;
      if (e == emax) begin
         if (f != 0) begin
            r.flags.nan = 1'b1;
            r.dbl = DblQnan;
         end else begin
            r.flags.inf = 1'b1;
            r.dbl = (sgn << 63) | DblInf;
         end
      end else if (e == 0) begin
         if (f == 0) begin
            r.flags.zero = 1'b1;
            r.dbl = sgn << 63;
         end else begin
            // subnormal: renormalize around the leading one
            r.flags.sub = 1'b1;
            scale = 1 - bias - fw;
            msb = 0;
            while (msb < 63 && (f >> (msb + 1)) != 0) msb++;
            bexp = msb + scale + 1023;
            if (bexp >= 1) begin
               frac = (f ^ (64'd1 << msb)) << (52 - msb);
               r.dbl = (sgn << 63) | (64'(bexp) << 52) | (frac & low_ones(52));
            end else begin
               sh = scale + 1074;
               frac = (sh >= 0 && sh < 64) ? (f << sh) : 64'd0;
               r.dbl = (sgn << 63) | (frac & low_ones(52));
            end
         end
      end else begin
         bexp = int'(e) - bias + 1023;
         frac = f << (52 - fw);
         r.dbl = (sgn << 63) | (64'(bexp) << 52) | (frac & low_ones(52));
      end
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(50, 20);
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side stalls
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ready = 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready = 1'b1;
         rsp_stall = gap_len();
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      conv_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report("unexpected result", rsp_double_bits, 64'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_double_bits !== want.dbl)
               report("double_bits", rsp_double_bits, want.dbl);
            if (rsp_is_nan !== want.flags.nan)
               report("is_nan", 64'(rsp_is_nan), 64'(want.flags.nan));
            if (rsp_is_infinite !== want.flags.inf)
               report("is_infinite", 64'(rsp_is_infinite), 64'(want.flags.inf));
            if (rsp_is_zero !== want.flags.zero)
               report("is_zero", 64'(rsp_is_zero), 64'(want.flags.zero));
            if (rsp_is_subnormal !== want.flags.sub)
               report("is_subnormal", 64'(rsp_is_subnormal), 64'(want.flags.sub));
            if (rsp_bad_config !== want.flags.bad)
               report("bad_config", 64'(rsp_bad_config), 64'(want.flags.bad));
         end
      end
   end

   // one pattern transfer; valid stays high for a back-to-back next item
   task automatic send_pattern(logic [PatWidth-1:0] pat);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_pattern = pat;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(convert(pat, fmt_total, fmt_frac));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // register writes only with the pipe empty
   task automatic set_format(int tw, int fw);
      drain();
      csr_write = 1'b1;
      csr_index = CSR_TOTAL_WIDTH;
      csr_data = TwWidth'(tw);
      @(negedge clock);
      csr_index = CSR_FRACTION_WIDTH;
      csr_data = {1'($urandom_range(1)), FwWidth'(fw)};
      @(negedge clock);
      csr_write = 1'b0;
      fmt_total = TwWidth'(tw);
      fmt_frac = FwWidth'(fw);
   endtask

   // build a pattern of a chosen class with junk above the format
   function automatic logic [PatWidth-1:0] shaped_pattern();
      int tw, fw, ew, cls;
      logic [63:0] emax, e, f, s, pat;
      tw = fmt_total;
      fw = fmt_frac;
      ew = tw - fw - 1;
      if (ew < 1 || ew > 11) return $urandom;
      emax = low_ones(ew);
      s = $urandom_range(1);
      f = {$urandom, $urandom} & low_ones(fw);
      cls = $urandom_range(7);
      case (cls)
         0: begin e = 0; f = 0; end
         1: begin
            e = 0;
            if (f == 0 && fw > 0) f = 64'd1 << $urandom_range(fw - 1);
         end
         2, 3, 4: e = (emax > 1) ? 64'($urandom_range(int'(emax) - 1, 1)) : 64'd0;
         5: begin e = emax; f = 0; end
         6: begin
            e = emax;
            if (f == 0 && fw > 0) f = 64'd1 << $urandom_range(fw - 1);
         end
         default: begin e = {$urandom} & emax; end
      endcase
      pat = ({32'd0, $urandom} & ~low_ones(tw)) | (s << (tw - 1)) | (e << fw) | f;
      return pat[PatWidth-1:0];
   endfunction

   task automatic run_random(int count);
      repeat (count) send_pattern(shaped_pattern());
   endtask

   // reset format: zero, subnormal and normal extremes, infinity, nan
   task automatic test_default_format();
      send_pattern(32'h0000_0000);
      send_pattern(32'h8000_0000);
      send_pattern(32'h0000_0001);
      send_pattern(32'h807F_FFFF);
      send_pattern(32'h0080_0000);
      send_pattern(32'h7F7F_FFFF);
      send_pattern(32'h7F80_0000);
      send_pattern(32'hFF80_0000);
      send_pattern(32'h7FC0_0001);
      send_pattern(32'hFFFF_FFFF);
      run_random(40);
   endtask

   // empty fraction, format wider than the input, widest exponent
   task automatic test_edge_formats();
      set_format(8, 0);
      send_pattern(32'hFFFF_FF00);
      send_pattern(32'h0000_007F);
      send_pattern(32'h0000_00FF);
      send_pattern(32'h0000_0001);
      set_format(2, 0);
      send_pattern(32'h0000_0000);
      send_pattern(32'h0000_0001);
      send_pattern(32'hFFFF_FFFE);
      set_format(43, 31);
      send_pattern(32'h0000_0001);
      send_pattern(32'h7FFF_FFFF);
      send_pattern(32'h8000_0000);
      send_pattern(32'hFFFF_FFFF);
      set_format(12, 0);
      send_pattern(32'h0000_07FF);
      send_pattern(32'h0000_0001);
      send_pattern(32'h0000_0800);
      set_format(3, 1);
      run_random(12);
      set_format(32, 20);
      run_random(12);
   endtask

   // exponent width out of range on both sides
   task automatic test_bad_formats();
      set_format(0, 0);
      send_pattern(32'hFFFF_FFFF);
      set_format(63, 31);
      send_pattern(32'h1234_5678);
      set_format(2, 1);
      send_pattern(32'h0000_0003);
      set_format(63, 0);
      send_pattern(32'h0000_0000);
      set_format(44, 31);
      run_random(6);
   endtask

   // many random formats, most of them legal
   task automatic test_random_formats();
      int ew, fw;
      for (int k = 0; k < 38; k++) begin
         no_idle = (k % 5 == 2);
         if ($urandom_range(9) == 0) begin
            set_format($urandom_range(63), $urandom_range(31));
         end else begin
            ew = $urandom_range(11, 1);
            fw = $urandom_range(31);
            set_format(ew + fw + 1, fw);
         end
         run_random(40);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_default_format();
      test_edge_formats();
      test_bad_formats();
      test_random_formats();
      drain();
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

// ===== files.f =====
hdl/cfd_pkg.sv
hdl/custom_float_to_double_top.sv
bench/tb_custom_float_to_double_top.sv
